FILE: src/psis_pkg.sv
// shared types and constants for the parity split in-place sort unit
// no dependencies; used by psis_cell, psis_chain and the top level
`default_nettype none

package psis_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] psis_data_t;

  // control handed from the sequencer to one sorted chain
  typedef struct packed {
    logic ins;  // insert the broadcast value this cycle
    logic pop;  // shift every cell toward the head by one
  } psis_chain_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } psis_state_t;

endpackage

`default_nettype wire

FILE: src/psis_cell.sv
// one compare-and-shift cell of a sorted chain
// depends on psis_pkg
`default_nettype none

module psis_cell (
  input  wire                            clk,
  input  wire psis_pkg::psis_chain_ctl_t ctl,
  input  wire psis_pkg::psis_data_t      new_val,     // broadcast insert value
  input  wire                            own_valid,   // this cell holds an element
  input  wire                            left_valid,  // left neighbor holds an element
  input  wire                            left_gt,     // left neighbor moves right
  input  wire psis_pkg::psis_data_t      left_val,
  input  wire psis_pkg::psis_data_t      right_val,
  output psis_pkg::psis_data_t           val,
  output logic                           gt           // this cell's element moves right
);

  psis_pkg::psis_data_t val_r, val_nxt;

  assign gt  = own_valid && (val_r > new_val);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.pop) begin
      val_nxt = right_val;
    end else if (ctl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || (!own_valid && left_valid)) begin
        val_nxt = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

FILE: src/psis_chain.sv
// ascending sorted chain built from a row of psis_cell, with its fill count
// depends on psis_pkg and psis_cell
`default_nettype none

module psis_chain #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire psis_pkg::psis_chain_ctl_t   ctl,
  input  wire psis_pkg::psis_data_t        new_val,
  output psis_pkg::psis_data_t             head,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [CW-1:0] count_r, count_nxt;

  psis_pkg::psis_data_t cell_val [DEPTH];
  logic [DEPTH-1:0]     cell_gt;
  logic [DEPTH-1:0]     cell_valid;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    psis_pkg::psis_data_t l_val, r_val;
    logic                 l_gt, l_valid;

    assign cell_valid[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign l_val   = '0;
      assign l_gt    = 1'b0;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_val   = cell_val[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign r_val = '0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
    end

    psis_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_val    (new_val),
      .own_valid  (cell_valid[i]),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .left_val   (l_val),
      .right_val  (r_val),
      .val        (cell_val[i]),
      .gt         (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end else if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = cell_val[0];
  assign count = count_r;

endmodule

`default_nettype wire

FILE: src/parity_split_inplace_sort_unit.sv
// parity split in-place sort unit: top level with load/drain sequencing
// depends on psis_pkg and psis_chain (which uses psis_cell)
//
// usage
// - input channel in_*: one signed 32-bit element per item, in_tlast closes
//   the block. even elements go into an ascending chain, odd elements into a
//   descending chain (stored inverted so both chains sort ascending), and one
//   parity bit per position is recorded.
// - load takes one item per cycle: every cell compares against the broadcast
//   value and shifts its neighbor's element in the same cycle.
// - after the closing item the block drains: one result per cycle on out_*,
//   N results for a block of N stored elements, position order; each position
//   takes the next element of its own parity chain. the first result is
//   registered once the drain state is entered and the output register is
//   free. in_tready is low while draining.
// - beyond MAX_ELEMS elements the extra items are dropped and out_tuser
//   (overflow) is high on every result of that block.
// - a stalled receiver simply holds the output register; draining resumes
//   when out_tready returns. input is taken again once the last result of
//   the block sits in the output register.
// - reset (rst_n low, synchronous) empties both chains and clears overflow.
`default_nettype none

module parity_split_inplace_sort_unit #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value_in
  input  wire         in_tlast,   // last_in

  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic        out_tlast,  // last_out
  output logic        out_tuser   // [0] overflow
);

  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned IW = $clog2(MAX_ELEMS);

  psis_pkg::psis_state_t state_r, state_nxt;

  psis_pkg::psis_chain_ctl_t even_ctl, odd_ctl;
  psis_pkg::psis_data_t      even_head, odd_head;
  logic [CW-1:0]             even_cnt, odd_cnt;

  logic [CW-1:0]        total;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAX_ELEMS-1:0] par_r;  // parity per position, odd = 1

  logic                 out_valid_r;
  psis_pkg::psis_data_t out_data_r;
  logic                 out_last_r, out_ovf_r;

  logic in_acc, room, store, odd_bit, can_load, pop_go, sel_odd;
  psis_pkg::psis_data_t pop_val;

  assign total    = CW'({1'b0, even_cnt} + {1'b0, odd_cnt});
  assign in_tready = (state_r == psis_pkg::ST_LOAD);
  assign in_acc   = in_tvalid && in_tready;
  assign room     = (total < CW'(MAX_ELEMS));
  assign store    = in_acc && room;
  assign odd_bit  = in_tdata[0];

  // while draining, pop one position whenever the output register is free
  assign can_load = !out_valid_r || out_tready;
  assign pop_go   = (state_r == psis_pkg::ST_DRAIN) && can_load;
  assign sel_odd  = par_r[0];

  always_comb begin
    even_ctl.ins = store && !odd_bit;
    even_ctl.pop = pop_go && !sel_odd && (even_cnt != '0);
    odd_ctl.ins  = store && odd_bit;
    odd_ctl.pop  = pop_go && sel_odd && (odd_cnt != '0);
  end

  // odd chain holds inverted values: ascending on ~v is descending on v
  psis_chain #(.DEPTH(MAX_ELEMS)) u_even (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (even_ctl),
    .new_val (psis_pkg::psis_data_t'(in_tdata)),
    .head    (even_head),
    .count   (even_cnt)
  );

  psis_chain #(.DEPTH(MAX_ELEMS)) u_odd (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (odd_ctl),
    .new_val (psis_pkg::psis_data_t'(~in_tdata)),
    .head    (odd_head),
    .count   (odd_cnt)
  );

  // an exhausted chain yields zero
  always_comb begin
    pop_val = '0;
    if (sel_odd) begin
      if (odd_cnt != '0) begin
        pop_val = ~odd_head;
      end
    end else if (even_cnt != '0) begin
      pop_val = even_head;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      psis_pkg::ST_LOAD: begin
        if (in_acc && !room) begin
          ovf_nxt = 1'b1;
        end
        if (in_acc && in_tlast) begin
          state_nxt = psis_pkg::ST_DRAIN;
          rem_nxt   = room ? (total + CW'(1)) : total;
        end
      end
      psis_pkg::ST_DRAIN: begin
        if (pop_go) begin
          rem_nxt = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = psis_pkg::ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = psis_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psis_pkg::ST_LOAD;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
      if (pop_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // parity line: written at the fill position, shifted toward bit 0 on drain
  always_ff @(posedge clk) begin
    if (store) begin
      par_r[total[IW-1:0]] <= odd_bit;
    end else if (pop_go) begin
      par_r <= par_r >> 1;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (pop_go) begin
      out_data_r <= pop_val;
      out_last_r <= (rem_r == CW'(1));
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for parity_split_inplace_sort_unit: sends blocks of signed elements and
// checks every rearranged block against a behavioral prediction of the sort
// depends on psis_pkg and parity_split_inplace_sort_unit

module tb;

  localparam int unsigned MAX_ELEMS      = 64;
  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned RANDOM_ITEMS   = 260;
  localparam int unsigned DIRECTED_ITEMS = 25;
  localparam int unsigned SETTLE_CYCLES  = 40;
  // slowest run is ~330 items and ~330 results
  localparam int unsigned LIMIT_CYCLES   = 200000;

  // one element on its way in
  typedef struct {
    psis_pkg::psis_data_t value;
    logic                 closes;
  } block_elem_t;

  // one rearranged element on its way out
  typedef struct {
    psis_pkg::psis_data_t value;
    logic                 last;
    logic                 overflow;
  } placed_elem_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_STREAM,   // always ready
    RX_COIN,     // ready at random, half the time
    RX_QUARTER,  // ready a quarter of the time, at a steady spacing
    RX_CHOKE     // long stalls, short ready windows
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [31:0] out_tdata;
  wire         out_tlast;
  wire         out_tuser;

  parity_split_inplace_sort_unit #(
    .MAX_ELEMS (MAX_ELEMS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] value_in
    .in_tlast   (in_tlast),    // last_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] value_out
    .out_tlast  (out_tlast),   // last_out
    .out_tuser  (out_tuser)    // [0] overflow
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // elements waiting for the driver, rearranged elements waiting for the block
  block_elem_t  pending_q[$];
  placed_elem_t placed_q[$];
  int unsigned  mismatches = 0;
  logic         in_taken   = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction: even values ascending, odd values descending, parity per slot
  // ---------------------------------------------------------------------------
  psis_pkg::psis_data_t even_asc[MAX_ELEMS];
  psis_pkg::psis_data_t odd_desc[MAX_ELEMS];
  logic                 parity_at[MAX_ELEMS];
  int unsigned          n_even  = 0;
  int unsigned          n_odd   = 0;
  logic                 dropped = 1'b0;

  task automatic place_element(input psis_pkg::psis_data_t v, input logic closes);
    int unsigned  stored;
    int unsigned  pos;
    int unsigned  ei;
    int unsigned  oi;
    int unsigned  p;
    placed_elem_t r;
    stored = n_even + n_odd;
    if (stored < MAX_ELEMS) begin
      parity_at[stored] = v[0];
      // bit 0 decides the class, so negative odd values land in the odd chain
      if (v[0]) begin
        pos = n_odd;
        while (pos > 0 && odd_desc[pos-1] < v) begin
          odd_desc[pos] = odd_desc[pos-1];
          pos--;
        end
        odd_desc[pos] = v;
        n_odd++;
      end else begin
        pos = n_even;
        while (pos > 0 && even_asc[pos-1] > v) begin
          even_asc[pos] = even_asc[pos-1];
          pos--;
        end
        even_asc[pos] = v;
        n_even++;
      end
      stored++;
    end else begin
      // store full: element dropped, the whole block is flagged
      dropped = 1'b1;
    end
    if (closes) begin
      ei = 0;
      oi = 0;
      for (p = 0; p < stored; p++) begin
        if (parity_at[p]) begin
          r.value = odd_desc[oi];
          oi++;
        end else begin
          r.value = even_asc[ei];
          ei++;
        end
        r.last     = (p + 1 == stored);
        r.overflow = dropped;
        placed_q.push_back(r);
      end
      n_even  = 0;
      n_odd   = 0;
      dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // rising edge: take accepted items into the prediction, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_edges
    placed_elem_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        place_element(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (placed_q.size() == 0) begin
          $error("result with nothing expected: value_out %0d last_out %b overflow %b",
                 $signed(out_tdata), out_tlast, out_tuser);
          mismatches++;
        end else begin
          want = placed_q.pop_front();
          if (out_tdata !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, $signed(out_tdata));
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("last_out: expected %b, got %b", want.last, out_tlast);
            mismatches++;
          end
          if (out_tuser !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, out_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input driver: bursts of items with random gaps, some bursts with no gap
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : drive_in
    logic        nv;
    logic [31:0] nd;
    logic        nl;
    block_elem_t it;
    nv = in_tvalid;
    nd = in_tdata;
    nl = in_tlast;
    // an offered item stays put until it has been taken
    if (rst_n && !(in_tvalid && !in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        nv = 1'b1;
        nd = it.value;
        nl = it.closes;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
    in_tlast  <= nl;
  end

  // ---------------------------------------------------------------------------
  // result receiver: stall pattern switches among the four rx modes at random
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode       = RX_STREAM;
  int unsigned rx_phase_left = 0;
  int unsigned rx_tick       = 0;

  always @(negedge clk) begin : drive_out_ready
    logic r;
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(16, 96);
    end
    rx_phase_left--;
    rx_tick++;
    case (rx_mode)
      RX_STREAM:  r = 1'b1;
      RX_COIN:    r = 1'($urandom_range(0, 1));
      RX_QUARTER: r = (rx_tick % 4) == 0;
      default:    r = (rx_tick % 24) >= 18;
    endcase
    out_tready <= r;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_elem(input psis_pkg::psis_data_t v, input logic closes);
    block_elem_t it;
    it.value  = v;
    it.closes = closes;
    pending_q.push_back(it);
  endtask

  // random block: half full-range values, plus small values for duplicates
  // and values hugging both ends of the range
  task automatic queue_random_block(input int unsigned len);
    psis_pkg::psis_data_t v;
    int unsigned          i;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: v = $urandom;
        4, 5:       v = $signed($urandom_range(0, 16)) - 8;
        6:          v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default:    v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 7)
                                             : 32'h8000_0000 + $urandom_range(0, 7);
      endcase
      push_elem(v, i + 1 == len);
    end
  endtask

  initial begin : stimulus
    int unsigned n_random;
    int unsigned len;

    // single-element blocks, one of each class
    push_elem(32'sd0, 1'b1);
    push_elem(-32'sd1, 1'b1);
    // both ends of the range and the values around zero, mixed classes
    push_elem(32'h7FFF_FFFF, 1'b0);
    push_elem(32'h8000_0000, 1'b0);
    push_elem(32'sd0, 1'b0);
    push_elem(-32'sd1, 1'b0);
    push_elem(32'sd1, 1'b0);
    push_elem(-32'sd2, 1'b0);
    push_elem(32'sd2, 1'b0);
    push_elem(32'h7FFF_FFFE, 1'b0);
    push_elem(32'h8000_0001, 1'b1);
    // duplicates in both classes
    push_elem(32'sd5, 1'b0);
    push_elem(32'sd5, 1'b0);
    push_elem(32'sd4, 1'b0);
    push_elem(32'sd4, 1'b0);
    push_elem(-32'sd3, 1'b0);
    push_elem(-32'sd3, 1'b1);
    // even values only, arriving descending
    push_elem(32'sd100, 1'b0);
    push_elem(32'sd6, 1'b0);
    push_elem(-32'sd6, 1'b0);
    push_elem(-32'sd100, 1'b1);
    // odd values only, arriving ascending
    push_elem(-32'sd99, 1'b0);
    push_elem(-32'sd7, 1'b0);
    push_elem(32'sd7, 1'b0);
    push_elem(32'sd99, 1'b1);

    // a block that exactly fills the store, then one that overflows and
    // closes on a dropped element
    queue_random_block(MAX_ELEMS);
    queue_random_block(MAX_ELEMS + 3);
    n_random = DIRECTED_ITEMS + 2 * MAX_ELEMS + 3;
    while (n_random < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_ELEMS, MAX_ELEMS + 6)
                                         : $urandom_range(1, 12);
      queue_random_block(len);
      n_random += len;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all items taken, then all results back, then a quiet tail for stray results
    while (pending_q.size() != 0 || in_tvalid) @(posedge clk);
    while (placed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** parity_split_inplace_sort_unit: PASSED **");
    end else begin
      $display("** parity_split_inplace_sort_unit: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("** parity_split_inplace_sort_unit: FAILED **");
    $finish;
  end

endmodule
